FILE: rtl/trie_keyword_masking_filter_top_assert.svh
// Assertion macros for the RTL of the keyword filter top module.
`ifndef TRIE_KEYWORD_MASKING_FILTER_TOP_ASSERT_SVH
`define TRIE_KEYWORD_MASKING_FILTER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property outside reset.
`define TKMF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check a property at every edge, reset included.
`define TKMF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TKMF_ASSERT(lbl, prop, msg)
`define TKMF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/tkmf_pkg.sv
package tkmf_pkg;

    localparam int CHAR_W = 16;

    // Reset value of the mask character register
    localparam logic [CHAR_W-1:0] MASK_RESET = 16'd42;

    // Register index of mask_char (paddr bit 2 selects the register)
    localparam logic REG_MASK_CHAR = 1'b0;

    // Input word kinds
    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_LOOK,
        S_WALK,
        S_TXT_LOOK,
        S_EMIT
    } t_state;

endpackage

FILE: rtl/tkmf_if.sv
interface tkmf_in_if;
    import tkmf_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, kind, char_code, last, input ready);
    modport sink   (input valid, kind, char_code, last, output ready);
endinterface

interface tkmf_out_if;
    import tkmf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_out;
    logic              masked;
    logic              text_end;
    logic              overflow;

    modport source (output valid, char_out, masked, text_end, overflow, input ready);
    modport sink   (input valid, char_out, masked, text_end, overflow, output ready);
endinterface

FILE: rtl/tkmf_ram.sv
module tkmf_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/trie_keyword_masking_filter_top.sv
// Trie keyword masking filter.
// Input channel i_in carries words of kind 0 (one dictionary word character each,
// last on the final one) or kind 1 (one text character each, last on the end of text).
// Output channel o_out carries filtered text characters: the original code, or
// mask_char with masked set where a dictionary word matched. text_end marks the final
// character of a text; overflow reflects the sticky word rejection flag.
// mask_char sits at APB address 0; write it only while the block is idle.
// Trie nodes live in one single-port-read RAM and every child lookup is a linear scan
// of the allocated nodes, one node per cycle.
// A dictionary word does one lookup (none if the word is aborted). A text word does one
// lookup per trie step of each walk (at most MAX_WORD steps) and then emits characters;
// a stalled receiver holds the emission. Input is taken only between words.
// No clearing pass: the RAM needs none after reset.
// Reset empties the trie (root only), the text window and the overflow flag and
// sets mask_char to 42. A stalled receiver holds the output register and the
// emission sequence; no result is dropped.
module trie_keyword_masking_filter_top #(
    parameter int NODES    = 1024,
    parameter int MAX_WORD = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tkmf_in_if.sink     i_in,
    tkmf_out_if.source  o_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import tkmf_pkg::*;

    `include "trie_keyword_masking_filter_top_assert.svh"

    localparam int AW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int FW = $clog2(MAX_WORD + 1);
    localparam int WW = $clog2(MAX_WORD);
    localparam int EW = AW + CHAR_W + 1;
    localparam logic [FW-1:0] MAX_FILL  = FW'(MAX_WORD);
    localparam logic [CW-1:0] NODE_MAX  = CW'(NODES);
    localparam logic [FW-1:0] ONE_F     = FW'(1);
    localparam logic [CW-1:0] ONE_C     = CW'(1);

    t_state r_state, n_state;

    logic [CHAR_W-1:0] r_mask, n_mask;
    logic [CHAR_W-1:0] r_win [MAX_WORD];
    logic [CHAR_W-1:0] n_win [MAX_WORD];
    logic [FW-1:0]     r_fill, n_fill;
    logic [FW-1:0]     r_k, n_k;
    logic [FW-1:0]     r_rem, n_rem;
    logic              r_msk, n_msk;
    logic              r_last, n_last;
    logic [AW-1:0]     r_cur, n_cur;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_icur, n_icur;
    logic [FW-1:0]     r_depth, n_depth;
    logic              r_abort, n_abort;
    logic              r_ovf, n_ovf;
    logic [CW-1:0]     r_sidx, n_sidx;
    logic              r_spend, n_spend;
    logic [AW-1:0]     r_spidx, n_spidx;
    logic [AW-1:0]     r_kp, n_kp;
    logic [CHAR_W-1:0] r_kc, n_kc;

    logic              r_ov, n_ov;
    logic [CHAR_W-1:0] r_oc, n_oc;
    logic              r_om, n_om;
    logic              r_oe, n_oe;
    logic              r_oo, n_oo;

    logic              in_fire;
    logic              emit_fire;
    logic              cfg_wr;
    logic              looking;
    logic              hit;
    logic              exhausted;
    logic [EW-1:0]     rd_data;
    logic [AW-1:0]     ent_par;
    logic [CHAR_W-1:0] ent_ch;
    logic              ent_end;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [EW-1:0]     wr_data;

    // Node table: {parent, character, end mark}
    tkmf_ram #(
        .WIDTH (EW),
        .DEPTH (NODES)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (looking),
        .i_raddr (r_sidx[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign ent_par = rd_data[EW-1 -: AW];
    assign ent_ch  = rd_data[CHAR_W:1];
    assign ent_end = rd_data[0];

    // Handshakes and scan status
    assign in_fire   = i_in.valid && i_in.ready;
    assign emit_fire = (r_state == S_EMIT) && (!r_ov || o_out.ready);
    assign cfg_wr    = i_psel && i_penable && i_pwrite;
    assign looking   = (r_state == S_INS_LOOK) || (r_state == S_TXT_LOOK);
    assign hit       = r_spend && (ent_par == r_kp) && (ent_ch == r_kc);
    assign exhausted = !hit && (r_sidx == r_count);

    // Ports
    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ov;
    assign o_out.char_out = r_oc;
    assign o_out.masked   = r_om;
    assign o_out.text_end = r_oe;
    assign o_out.overflow = r_oo;
    assign o_pready       = 1'b1;
    assign o_prdata       = (i_paddr[2] == REG_MASK_CHAR) ? {16'd0, r_mask} : 32'd0;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.kind == KIND_TEXT) begin
                        n_state = S_WALK;
                    end else if (!r_abort && (r_depth < MAX_FILL)) begin
                        n_state = S_INS_LOOK;
                    end
                end
            end
            S_INS_LOOK: begin
                if (hit || exhausted) begin
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (r_k != r_fill) begin
                    n_state = S_TXT_LOOK;
                end else if (r_last || (r_fill == MAX_FILL)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TXT_LOOK: begin
                if (hit) begin
                    n_state = ent_end ? S_EMIT : S_WALK;
                end else if (exhausted) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_fire && (r_rem == ONE_F)) begin
                    n_state = (r_fill == ONE_F) ? S_IDLE : S_WALK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and node table writes
    always_comb begin
        n_mask  = r_mask;
        n_win   = r_win;
        n_fill  = r_fill;
        n_k     = r_k;
        n_rem   = r_rem;
        n_msk   = r_msk;
        n_last  = r_last;
        n_cur   = r_cur;
        n_count = r_count;
        n_icur  = r_icur;
        n_depth = r_depth;
        n_abort = r_abort;
        n_ovf   = r_ovf;
        n_sidx  = r_sidx;
        n_spend = r_spend;
        n_spidx = r_spidx;
        n_kp    = r_kp;
        n_kc    = r_kc;
        n_ov    = r_ov;
        n_oc    = r_oc;
        n_om    = r_om;
        n_oe    = r_oe;
        n_oo    = r_oo;
        wr_en   = 1'b0;
        wr_addr = r_spidx;
        wr_data = {r_kp, r_kc, r_last};

        if (cfg_wr && (i_paddr[2] == REG_MASK_CHAR)) begin
            n_mask = i_pwdata[CHAR_W-1:0];
        end

        // Advance the scan pointer while looking
        if (looking && !hit && !exhausted) begin
            n_sidx  = r_sidx + ONE_C;
            n_spend = 1'b1;
            n_spidx = r_sidx[AW-1:0];
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_last = i_in.last;
                    if (i_in.kind == KIND_TEXT) begin
                        if (r_fill < MAX_FILL) begin
                            n_win[r_fill[WW-1:0]] = i_in.char_code;
                            n_fill = r_fill + ONE_F;
                        end
                        n_k   = '0;
                        n_cur = '0;
                    end else if (!r_abort && (r_depth < MAX_FILL)) begin
                        n_kp    = r_icur;
                        n_kc    = i_in.char_code;
                        n_sidx  = ONE_C;
                        n_spend = 1'b0;
                    end else if (i_in.last) begin
                        n_ovf   = 1'b1;
                        n_icur  = '0;
                        n_depth = '0;
                        n_abort = 1'b0;
                    end else begin
                        n_abort = 1'b1;
                    end
                end
            end
            S_INS_LOOK: begin
                if (hit) begin
                    // Descend into the existing child; mark it on the last character
                    n_icur  = r_spidx;
                    n_depth = r_depth + ONE_F;
                    wr_en   = r_last;
                    wr_addr = r_spidx;
                    if (r_last) begin
                        n_icur  = '0;
                        n_depth = '0;
                    end
                end else if (exhausted) begin
                    if (r_count == NODE_MAX) begin
                        if (r_last) begin
                            n_ovf   = 1'b1;
                            n_icur  = '0;
                            n_depth = '0;
                            n_abort = 1'b0;
                        end else begin
                            n_abort = 1'b1;
                        end
                    end else begin
                        // Allocate a new node, end-marked on the last character
                        wr_en   = 1'b1;
                        wr_addr = r_count[AW-1:0];
                        n_count = r_count + ONE_C;
                        n_icur  = r_count[AW-1:0];
                        n_depth = r_depth + ONE_F;
                        if (r_last) begin
                            n_icur  = '0;
                            n_depth = '0;
                        end
                    end
                end
            end
            S_WALK: begin
                if (r_k != r_fill) begin
                    n_kp    = r_cur;
                    n_kc    = r_win[r_k[WW-1:0]];
                    n_sidx  = ONE_C;
                    n_spend = 1'b0;
                end else begin
                    n_rem = ONE_F;
                    n_msk = 1'b0;
                end
            end
            S_TXT_LOOK: begin
                if (hit) begin
                    n_cur = r_spidx;
                    if (ent_end) begin
                        n_rem = r_k + ONE_F;
                        n_msk = 1'b1;
                    end else begin
                        n_k = r_k + ONE_F;
                    end
                end else if (exhausted) begin
                    n_rem = ONE_F;
                    n_msk = 1'b0;
                end
            end
            S_EMIT: begin
                if (emit_fire) begin
                    n_oc   = r_msk ? r_mask : r_win[0];
                    n_om   = r_msk;
                    n_oe   = r_last && (r_fill == ONE_F);
                    n_oo   = r_ovf;
                    // Drop the oldest character
                    for (int i = 0; i < MAX_WORD - 1; i++) begin
                        n_win[i] = r_win[i + 1];
                    end
                    n_fill = r_fill - ONE_F;
                    n_rem  = r_rem - ONE_F;
                    n_k    = '0;
                    n_cur  = '0;
                end
            end
            default: begin
            end
        endcase

        // Output register: load on emit, release when taken
        if (emit_fire) begin
            n_ov = 1'b1;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mask  <= MASK_RESET;
            r_fill  <= '0;
            r_k     <= '0;
            r_rem   <= '0;
            r_msk   <= 1'b0;
            r_last  <= 1'b0;
            r_count <= ONE_C;
            r_icur  <= '0;
            r_depth <= '0;
            r_abort <= 1'b0;
            r_ovf   <= 1'b0;
            r_sidx  <= ONE_C;
            r_spend <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mask  <= n_mask;
            r_fill  <= n_fill;
            r_k     <= n_k;
            r_rem   <= n_rem;
            r_msk   <= n_msk;
            r_last  <= n_last;
            r_count <= n_count;
            r_icur  <= n_icur;
            r_depth <= n_depth;
            r_abort <= n_abort;
            r_ovf   <= n_ovf;
            r_sidx  <= n_sidx;
            r_spend <= n_spend;
            r_ov    <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_win   <= n_win;
        r_cur   <= n_cur;
        r_spidx <= n_spidx;
        r_kp    <= n_kp;
        r_kc    <= n_kc;
        r_oc    <= n_oc;
        r_om    <= n_om;
        r_oe    <= n_oe;
        r_oo    <= n_oo;
    end

    `TKMF_ASSERT(a_fill_bound, (r_fill <= MAX_FILL), "window fill beyond MAX_WORD")
    `TKMF_ASSERT(a_count_bound, (r_count >= ONE_C && r_count <= NODE_MAX), "node count range")
    `TKMF_ASSERT(a_idle_not_full, (r_state == S_IDLE) |-> (r_fill < MAX_FILL), "full idle")
    `TKMF_ASSERT(a_emit_nonzero, (r_state == S_EMIT) |-> (r_rem != '0 && r_fill != '0), "empty")
    `TKMF_ASSERT_ALWAYS(a_pready_high, o_pready, "pready low")

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    import tkmf_pkg::*;

    localparam int NODES    = 1024;
    localparam int MAX_WORD = 16;
    localparam int STALL_LIMIT = 400000;
    localparam int MAX_DICT = 48;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              masked;
        logic              text_end;
        logic              overflow;
    } t_filt_char;

    typedef struct {
        logic              kind;
        logic [CHAR_W-1:0] code;
        logic              last;
        bit                chk;
        logic [CHAR_W-1:0] first_code;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tkmf_in_if  in_if ();
    tkmf_out_if out_if ();

    trie_keyword_masking_filter_top #(.NODES(NODES), .MAX_WORD(MAX_WORD)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_if),
        .o_out     (out_if),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    // Shadow trie and text window
    int unsigned       node_parent [NODES];
    logic [CHAR_W-1:0] node_ch     [NODES];
    bit                node_end    [NODES];
    int unsigned       node_cnt;
    int unsigned       ins_cursor;
    int unsigned       ins_depth;
    bit                ins_abort;
    bit                ovf_flag;
    logic [CHAR_W-1:0] window_q [MAX_WORD];
    int unsigned       window_fill;
    logic [CHAR_W-1:0] mask_code;

    t_filt_char filtered_q[$];
    int  mismatches;
    int  quiet_cycles;
    bit  calm;

    // Dictionary words kept for building matching text
    logic [CHAR_W-1:0] dict_chars [MAX_DICT][4];
    int                dict_len   [MAX_DICT];
    int                dict_n;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned child_of(int unsigned p, logic [CHAR_W-1:0] c);
        for (int unsigned n = 1; n < node_cnt && n < NODES; n++) begin
            if (node_parent[n] == p && node_ch[n] == c) return n;
        end
        return 0;
    endfunction

    // Shortest match length at window head; 0 none, -1 wait for more text
    function automatic int match_len(bit flush);
        int unsigned cur;
        int unsigned nx;
        cur = 0;
        for (int unsigned k = 0; k < window_fill && k < MAX_WORD; k++) begin
            nx = child_of(cur, window_q[k]);
            if (nx == 0) return 0;
            cur = nx;
            if (node_end[cur]) return k + 1;
        end
        if (flush || window_fill >= MAX_WORD) return 0;
        return -1;
    endfunction

    function automatic void add_dict_char(logic [CHAR_W-1:0] c, bit last);
        int unsigned nx;
        if (!ins_abort) begin
            if (ins_depth >= MAX_WORD) begin
                ins_abort = 1;
            end else begin
                nx = child_of(ins_cursor, c);
                if (nx == 0) begin
                    if (node_cnt >= NODES) begin
                        ins_abort = 1;
                    end else begin
                        nx = node_cnt;
                        node_parent[nx] = ins_cursor;
                        node_ch[nx] = c;
                        node_end[nx] = 0;
                        node_cnt++;
                    end
                end
                if (!ins_abort) begin
                    ins_cursor = nx;
                    ins_depth++;
                end
            end
        end
        if (last) begin
            if (ins_abort) ovf_flag = 1;
            else if (ins_cursor != 0) node_end[ins_cursor] = 1;
            ins_cursor = 0;
            ins_depth = 0;
            ins_abort = 0;
        end
    endfunction

    // Advance the shadow filter by one accepted word; returns results queued
    function automatic int filter_step(logic kind, logic [CHAR_W-1:0] c, logic last);
        int len;
        int cnt;
        t_filt_char r;
        cnt = 0;
        if (kind == KIND_WORD) begin
            add_dict_char(c, last);
            return 0;
        end
        if (window_fill < MAX_WORD) begin
            window_q[window_fill] = c;
            window_fill++;
        end
        while (window_fill > 0) begin
            len = match_len(last);
            if (len < 0) break;
            if (len == 0) begin
                r = '{ch: window_q[0], masked: 1'b0, text_end: 1'b0, overflow: ovf_flag};
                filtered_q.push_back(r);
                cnt++;
                len = 1;
            end else begin
                for (int i = 0; i < len; i++) begin
                    r = '{ch: mask_code, masked: 1'b1, text_end: 1'b0, overflow: ovf_flag};
                    filtered_q.push_back(r);
                    cnt++;
                end
            end
            for (int unsigned i = 0; i + len < window_fill; i++) window_q[i] = window_q[i + len];
            window_fill -= len;
        end
        if (last && cnt > 0) filtered_q[filtered_q.size() - 1].text_end = 1'b1;
        return cnt;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 15);
        if (calm || r < 9) return 0;
        if (r < 15) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // Present one word and hold it until the block takes it
    task automatic send(logic kind, logic [CHAR_W-1:0] c, logic last, output int n_res);
        int g;
        g = gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid = 1'b1;
        in_if.kind = kind;
        in_if.char_code = c;
        in_if.last = last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        n_res = filter_step(kind, c, last);
    endtask

    task automatic put(logic kind, logic [CHAR_W-1:0] c, logic last);
        int n;
        send(kind, c, last, n);
    endtask

    task automatic apb_write(logic [2:0] a, logic [31:0] d);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = a; pwdata = d;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (a[2] == REG_MASK_CHAR) mask_code = d[CHAR_W-1:0];
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic apb_check(logic [2:0] a, logic [31:0] want);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = a;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[CHAR_W-1:0] !== want[CHAR_W-1:0]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mask_char read: expected %h got %h",
                         want[CHAR_W-1:0], prdata[CHAR_W-1:0]);
        end
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0;
    endtask

    // Drain all results, then let in-flight dictionary work finish
    task automatic settle();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (256 * (node_cnt + 2) + 20) @(posedge i_clk);
    endtask

    // Random words of a small alphabet, sometimes a full 16-bit code
    task automatic add_random_word();
        int len;
        logic [CHAR_W-1:0] c;
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
            c = ($urandom_range(0, 7) == 0) ? CHAR_W'($urandom)
                                            : CHAR_W'(16'h61 + $urandom_range(0, 3));
            if (dict_n < MAX_DICT) dict_chars[dict_n][i] = c;
            put(KIND_WORD, c, i == len - 1);
        end
        if (dict_n < MAX_DICT) begin
            dict_len[dict_n] = len;
            dict_n++;
        end
    endtask

    task automatic random_phase(int items);
        int sent;
        int r;
        int w;
        bit fin;
        sent = 0;
        while (sent < items) begin
            r = $urandom_range(0, 9);
            if (r < 2 && dict_n < MAX_DICT) begin
                add_random_word();
            end else if (r == 2) begin
                put(KIND_TEXT, CHAR_W'($urandom), $urandom_range(0, 7) == 0);
                sent++;
            end else if (dict_n > 0 && r < 8) begin
                w = $urandom_range(0, dict_n - 1);
                for (int i = 0; i < dict_len[w]; i++) begin
                    fin = (i == dict_len[w] - 1) && ($urandom_range(0, 3) == 0);
                    put(KIND_TEXT, dict_chars[w][i], fin);
                    sent++;
                end
            end else begin
                put(KIND_TEXT, CHAR_W'(16'h61 + $urandom_range(0, 3)), $urandom_range(0, 5) == 0);
                sent++;
            end
        end
        put(KIND_TEXT, CHAR_W'(16'h61 + $urandom_range(0, 3)), 1'b1);
    endtask

    // Output ready with bursts of stall
    int stall_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_if.ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 3);
        end
    end

    // Compare each filtered word with the oldest expectation
    always @(posedge i_clk) begin
        t_filt_char want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (filtered_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: char %h masked %b end %b ovf %b",
                             out_if.char_out, out_if.masked, out_if.text_end, out_if.overflow);
            end else begin
                want = filtered_q.pop_front();
                if (out_if.char_out !== want.ch || out_if.masked !== want.masked ||
                    out_if.text_end !== want.text_end || out_if.overflow !== want.overflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
                                 want.ch, want.masked, want.text_end, want.overflow,
                                 out_if.char_out, out_if.masked, out_if.text_end,
                                 out_if.overflow);
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("trie_keyword_masking_filter_top: mismatch");
                $finish;
            end
        end
    end

    t_stim_row rows[$];

    initial begin
        int n;
        in_if.valid = 1'b0;
        in_if.kind = KIND_TEXT;
        in_if.char_code = '0;
        in_if.last = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0;
        calm = 0;
        dict_n = 0;
        node_cnt = 1;
        ins_cursor = 0; ins_depth = 0; ins_abort = 0; ovf_flag = 0;
        window_fill = 0;
        mask_code = MASK_RESET;
        for (int i = 0; i < NODES; i++) begin
            node_parent[i] = 0; node_ch[i] = '0; node_end[i] = 0;
        end
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        apb_check(3'd0, 32'(MASK_RESET));

        // Directed: empty dictionary, extremes, pending walks, mid-text words
        rows = '{
            '{KIND_TEXT, 16'h0000, 1'b0, 1'b1, 16'h0000},
            '{KIND_TEXT, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
            '{KIND_WORD, 16'h0061, 1'b0, 1'b0, 16'h0},
            '{KIND_WORD, 16'h0062, 1'b1, 1'b0, 16'h0},
            '{KIND_WORD, 16'h0062, 1'b0, 1'b0, 16'h0},
            '{KIND_WORD, 16'h0063, 1'b1, 1'b0, 16'h0},
            '{KIND_WORD, 16'hFFFF, 1'b0, 1'b0, 16'h0},
            '{KIND_WORD, 16'h0000, 1'b1, 1'b0, 16'h0},
            '{KIND_WORD, 16'h0078, 1'b1, 1'b0, 16'h0},
            '{KIND_TEXT, 16'h0078, 1'b0, 1'b1, MASK_RESET},
            '{KIND_TEXT, 16'h0061, 1'b0, 1'b0, 16'h0},
            '{KIND_TEXT, 16'h0062, 1'b0, 1'b0, 16'h0},
            '{KIND_TEXT, 16'h0061, 1'b1, 1'b0, 16'h0},
            '{KIND_TEXT, 16'hFFFF, 1'b0, 1'b0, 16'h0},
            '{KIND_TEXT, 16'h0000, 1'b0, 1'b0, 16'h0},
            '{KIND_TEXT, 16'h0062, 1'b0, 1'b0, 16'h0},
            '{KIND_TEXT, 16'h0071, 1'b1, 1'b0, 16'h0},
            '{KIND_TEXT, 16'h0062, 1'b0, 1'b0, 16'h0},
            '{KIND_WORD, 16'h0062, 1'b0, 1'b0, 16'h0},
            '{KIND_WORD, 16'h0064, 1'b1, 1'b0, 16'h0},
            '{KIND_TEXT, 16'h0064, 1'b1, 1'b1, MASK_RESET},
            '{KIND_TEXT, 16'h5A5A, 1'b1, 1'b1, 16'h5A5A}
        };
        foreach (rows[i]) begin
            send(rows[i].kind, rows[i].code, rows[i].last, n);
            if (rows[i].chk && (n == 0 ||
                filtered_q[filtered_q.size() - n].ch !== rows[i].first_code)) begin
                mismatches++;
                if (mismatches <= 10) $display("stimulus row %0d: first char not %h", i,
                                               rows[i].first_code);
            end
        end
        settle();

        // Long word: nodes stay without end mark, overflow sets
        apb_write(3'd0, 32'h0000FFFF);
        for (int i = 0; i <= MAX_WORD; i++) put(KIND_WORD, 16'h006B, i == MAX_WORD);
        // Full window on an endless path emits the head unchanged
        for (int i = 0; i < MAX_WORD; i++) put(KIND_TEXT, 16'h006B, 1'b0);
        put(KIND_TEXT, 16'h0078, 1'b1);
        settle();
        apb_write(3'd0, 32'h00000000);

        // Random phases, one calm, mask rewritten between them
        for (int p = 0; p < 4; p++) begin
            calm = (p == 2);
            random_phase(55);
            settle();
            apb_write(3'd0, $urandom_range(0, 65535));
        end
        calm = 0;

        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (4 * (node_cnt + 2) + 50) @(posedge i_clk);

        if (mismatches == 0 && filtered_q.size() == 0) begin
            $display("trie_keyword_masking_filter_top: match");
        end else begin
            $display("trie_keyword_masking_filter_top: mismatch");
        end
        $finish;
    end

endmodule
